// File: src/assert_macros.svh
// Assertion helpers shared by the checking code in the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Condition that must never be seen.
`define APC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/apc_pkg.sv
package apc_pkg;

    // Status codes reported with the end-of-packet result
    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_SHORT    = 4'd1,
        ERR_LENGTH   = 4'd2,
        ERR_MAGIC    = 4'd3,
        ERR_VERSION  = 4'd4,
        ERR_TYPE     = 4'd5,
        ERR_HEADER   = 4'd6,
        ERR_GEOMETRY = 4'd7,
        ERR_CHECKSUM = 4'd8
    } t_err;

    // Configuration register indexes
    localparam logic [1:0] CFG_VERSION    = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN    = 2'd1;
    localparam logic [1:0] CFG_FLAGS_MASK = 2'd2;

    // Result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Protocol constants
    localparam logic [7:0]  MAGIC_S     = 8'h53;
    localparam logic [7:0]  MAGIC_N     = 8'h4E;
    localparam logic [7:0]  MAGIC_P     = 8'h50;
    localparam logic [7:0]  PKT_TYPE    = 8'd1;
    localparam logic [7:0]  CHANNELS    = 8'd2;
    localparam logic [7:0]  FORMAT_S16  = 8'd1;
    localparam logic [31:0] RATE_44K1   = 32'd44100;
    localparam logic [31:0] RATE_48K    = 32'd48000;
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
    localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;

    // Header bytes 0..35 carry every field that is checked or reported, but for the CRC field
    localparam int FIELD_BYTES = 36;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    typedef logic [Q_PTR_W-1:0] t_qptr;
    typedef logic [Q_PTR_W:0]   t_qcnt;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
        t_err        error_code;
        logic [31:0] session_tag;
        logic [31:0] sequence_res;
        logic [63:0] pts_frame;
        logic [31:0] rate_hz;
        logic [15:0] frames;
        logic [15:0] flag_bits;
        logic        last;
    } t_result;

    // One byte of reflected CRC-32, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

endpackage

// File: src/audio_packet_checker_top.sv
// Path: a byte accepted into the input register is checked there once the queue has room, and its
//   results are written into the result queue, whose head drives the output; a status is queued behind its sample.
// Throughput: one byte per cycle; a 4-entry result queue absorbs the extra status result,
//   and input stalls only when the queue holds more than 2 results.
// Reset: synchronous, active low; clears packet state, queue and registers to defaults.
module audio_packet_checker_top #(
    parameter int HDR_LEN       = 40,
    parameter int CRC_FIELD_POS = 36
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_packet,
    // result output
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic signed [15:0] o_sample,
    output logic [3:0]         o_error_code,
    output logic [31:0]        o_session_tag,
    output logic [31:0]        o_sequence_res,
    output logic [63:0]        o_pts_frame,
    output logic [31:0]        o_rate_hz,
    output logic [15:0]        o_frames,
    output logic [15:0]        o_flag_bits,
    output logic               o_last,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    `include "assert_macros.svh"

    localparam logic [16:0] HB17 = 17'(HDR_LEN);
    localparam logic [16:0] CO17 = 17'(CRC_FIELD_POS);

    // Configuration registers
    logic [7:0]  r_version;
    logic [16:0] r_max_len;
    logic [15:0] r_flags_mask;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eop;

    // Per-packet state
    logic [16:0] r_count;
    logic        r_ovf;
    logic [31:0] r_crc;
    logic [7:0]  r_low;
    logic [7:0]  r_hdr [apc_pkg::FIELD_BYTES];
    logic [7:0]  r_chk [4];

    // Result queue
    apc_pkg::t_result r_q [apc_pkg::Q_DEPTH];
    apc_pkg::t_qptr   r_wr;
    apc_pkg::t_qptr   r_rd;
    apc_pkg::t_qcnt   r_cnt;

    logic        w_proc;
    logic        w_in_take;
    logic        w_pop;
    logic        w_live;
    logic        w_chk_win;
    logic        w_payload;
    logic        w_odd;
    logic        w_emit;
    logic [7:0]  w_crc_in;
    logic [31:0] n_crc;
    logic [16:0] n_count;
    logic        n_ovf;
    logic [7:0]  w_hdr [apc_pkg::FIELD_BYTES];
    logic [7:0]  w_chk [4];
    logic [31:0] w_rate;
    logic [15:0] w_frames;
    logic [15:0] w_flags;
    logic [15:0] w_paylen;
    logic [17:0] w_expect;
    logic [31:0] w_stored;
    apc_pkg::t_err    w_err;
    apc_pkg::t_result w_sample_res;
    apc_pkg::t_result w_status_res;
    logic [1:0]  w_push;

    // Handshakes
    assign w_proc    = r_in_valid && (r_cnt <= apc_pkg::t_qcnt'(apc_pkg::Q_DEPTH - 2));
    assign o_stall   = r_in_valid && !w_proc;
    assign w_in_take = i_valid && !o_stall;
    assign o_valid   = (r_cnt != '0);
    assign w_pop     = o_valid && !i_stall;
    assign o_cfg_ready = 1'b1;

    // Byte position decode
    assign w_live    = !r_ovf;
    assign w_chk_win = w_live && (r_count >= CO17) && (r_count < CO17 + 17'd4);
    assign w_payload = w_live && (r_count >= HB17);
    assign w_odd     = r_count[0] ^ HB17[0];
    assign w_emit    = w_payload && w_odd;
    assign w_crc_in  = w_chk_win ? 8'd0 : r_in_byte;
    assign n_crc     = apc_pkg::crc_byte(r_crc, w_crc_in);

    // Saturating byte count
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_live) begin
            if (r_count == apc_pkg::COUNT_MAX) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 17'd1;
            end
        end
    end

    // Header and checksum stores with the current byte merged in
    always_comb begin
        for (int k = 0; k < apc_pkg::FIELD_BYTES; k++) begin
            w_hdr[k] = (w_live && r_count == 17'(k)) ? r_in_byte : r_hdr[k];
        end
        for (int k = 0; k < 4; k++) begin
            w_chk[k] = (w_live && r_count == CO17 + 17'(k)) ? r_in_byte : r_chk[k];
        end
    end

    assign w_rate   = {w_hdr[27], w_hdr[26], w_hdr[25], w_hdr[24]};
    assign w_frames = {w_hdr[29], w_hdr[28]};
    assign w_paylen = {w_hdr[33], w_hdr[32]};
    assign w_flags  = {w_hdr[35], w_hdr[34]};
    assign w_expect = {w_frames, 2'b00};
    assign w_stored = {w_chk[3], w_chk[2], w_chk[1], w_chk[0]};

    // Verdict, first failing check wins
    always_comb begin
        priority if (!n_ovf && n_count < HB17) begin
            w_err = apc_pkg::ERR_SHORT;
        end else if (n_ovf || n_count > r_max_len) begin
            w_err = apc_pkg::ERR_LENGTH;
        end else if (w_hdr[0] != apc_pkg::MAGIC_S || w_hdr[1] != apc_pkg::MAGIC_S ||
                     w_hdr[2] != apc_pkg::MAGIC_N || w_hdr[3] != apc_pkg::MAGIC_P) begin
            w_err = apc_pkg::ERR_MAGIC;
        end else if (w_hdr[4] != r_version) begin
            w_err = apc_pkg::ERR_VERSION;
        end else if (w_hdr[5] != apc_pkg::PKT_TYPE) begin
            w_err = apc_pkg::ERR_TYPE;
        end else if ({w_hdr[7], w_hdr[6]} != 16'(HDR_LEN)) begin
            w_err = apc_pkg::ERR_HEADER;
        end else if (w_hdr[30] != apc_pkg::CHANNELS ||
                     (w_rate != apc_pkg::RATE_44K1 && w_rate != apc_pkg::RATE_48K) ||
                     w_hdr[31] != apc_pkg::FORMAT_S16 || w_frames == 16'd0) begin
            w_err = apc_pkg::ERR_GEOMETRY;
        end else if ((w_flags & ~r_flags_mask) != 16'd0) begin
            w_err = apc_pkg::ERR_HEADER;
        end else if ({2'b00, w_paylen} != w_expect ||
                     {2'b00, n_count} != 19'(HDR_LEN) + {1'b0, w_expect}) begin
            w_err = apc_pkg::ERR_LENGTH;
        end else if (w_stored != ~n_crc) begin
            w_err = apc_pkg::ERR_CHECKSUM;
        end else begin
            w_err = apc_pkg::ERR_OK;
        end
    end

    // Result words
    always_comb begin
        w_sample_res        = '0;
        w_sample_res.kind   = apc_pkg::KIND_SAMPLE;
        w_sample_res.sample = {r_in_byte, r_low};

        w_status_res              = '0;
        w_status_res.kind         = apc_pkg::KIND_STATUS;
        w_status_res.error_code   = w_err;
        w_status_res.session_tag  = {w_hdr[11], w_hdr[10], w_hdr[9], w_hdr[8]};
        w_status_res.sequence_res = {w_hdr[15], w_hdr[14], w_hdr[13], w_hdr[12]};
        w_status_res.pts_frame    = {w_hdr[23], w_hdr[22], w_hdr[21], w_hdr[20],
                                     w_hdr[19], w_hdr[18], w_hdr[17], w_hdr[16]};
        w_status_res.rate_hz      = w_rate;
        w_status_res.frames       = w_frames;
        w_status_res.flag_bits    = w_flags;
        w_status_res.last         = 1'b1;
    end

    assign w_push = w_proc ? ({1'b0, w_emit} + {1'b0, r_in_eop}) : 2'd0;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version    <= 8'd1;
            r_max_len    <= 17'd1472;
            r_flags_mask <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                apc_pkg::CFG_VERSION:    r_version    <= i_cfg_data[7:0];
                apc_pkg::CFG_MAX_LEN:    r_max_len    <= i_cfg_data;
                apc_pkg::CFG_FLAGS_MASK: r_flags_mask <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_data_byte;
            r_in_eop  <= i_end_of_packet;
        end
    end

    // Packet state, cleared after the status result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_crc   <= apc_pkg::CRC_INIT;
            r_low   <= '0;
            for (int k = 0; k < apc_pkg::FIELD_BYTES; k++) r_hdr[k] <= '0;
            for (int k = 0; k < 4; k++) r_chk[k] <= '0;
        end else if (w_proc) begin
            if (r_in_eop) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_crc   <= apc_pkg::CRC_INIT;
                r_low   <= '0;
                for (int k = 0; k < apc_pkg::FIELD_BYTES; k++) r_hdr[k] <= '0;
                for (int k = 0; k < 4; k++) r_chk[k] <= '0;
            end else begin
                r_count <= n_count;
                r_ovf   <= n_ovf;
                r_crc   <= n_crc;
                if (w_payload && !w_odd) begin
                    r_low <= r_in_byte;
                end
                for (int k = 0; k < apc_pkg::FIELD_BYTES; k++) r_hdr[k] <= w_hdr[k];
                for (int k = 0; k < 4; k++) r_chk[k] <= w_chk[k];
            end
        end
    end

    // Result queue: sample first, then status
    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            if (w_emit) begin
                r_q[r_wr] <= w_sample_res;
            end
            if (r_in_eop) begin
                r_q[r_wr + apc_pkg::t_qptr'(w_emit)] <= w_status_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + apc_pkg::t_qptr'(w_push);
            r_rd  <= r_rd + apc_pkg::t_qptr'(w_pop);
            r_cnt <= r_cnt + apc_pkg::t_qcnt'(w_push) - apc_pkg::t_qcnt'(w_pop);
        end
    end

    // Output from queue head
    assign o_kind         = r_q[r_rd].kind;
    assign o_sample       = r_q[r_rd].sample;
    assign o_error_code   = r_q[r_rd].error_code;
    assign o_session_tag  = r_q[r_rd].session_tag;
    assign o_sequence_res = r_q[r_rd].sequence_res;
    assign o_pts_frame    = r_q[r_rd].pts_frame;
    assign o_rate_hz      = r_q[r_rd].rate_hz;
    assign o_frames       = r_q[r_rd].frames;
    assign o_flag_bits    = r_q[r_rd].flag_bits;
    assign o_last         = r_q[r_rd].last;

    // Checks
    `APC_ASSERT_NEVER(a_q_over, i_clk, i_rst_n, r_cnt > apc_pkg::t_qcnt'(apc_pkg::Q_DEPTH), "result queue overflow")
    `APC_ASSERT_NEVER(a_in_lost, i_clk, i_rst_n, w_in_take && r_in_valid && !w_proc, "held byte overwritten")
    `APC_ASSERT_NEXT(a_status_out, i_clk, i_rst_n, w_proc && r_in_eop, o_valid, "status not queued")
    `APC_ASSERT_NEXT(a_pkt_clear, i_clk, i_rst_n, w_proc && r_in_eop, r_count == '0 && !r_ovf, "packet state not cleared")
    `APC_ASSERT_IMPL(a_emit_live, i_clk, i_rst_n, w_emit, !r_ovf && r_count >= HB17, "sample outside payload")

endmodule
